// ----- sv/pgdfr_pkg.sv -----
// shared types and constants for the frontend message deframer
// no dependencies; imported by every module of the block
`default_nettype none

package pgdfr_pkg;

    localparam int unsigned OFFSET_WIDTH_DEFAULT = 27;
    localparam int unsigned BODY_OFFSET_W        = 27;

    localparam logic [31:0] MAX_TOTAL_DEFAULT = 32'h0400_0000;
    localparam logic [31:0] HDR_LEN           = 32'd4;
    localparam logic [2:0]  HDR_COUNT_FULL    = 3'd4;
    localparam logic [2:0]  HDR_COUNT_REUSE   = 3'd3;

    typedef enum logic [2:0] {
        PH_SU_LEN  = 3'd0,
        PH_SU_BODY = 3'd1,
        PH_TYPE    = 3'd2,
        PH_LEN     = 3'd3,
        PH_BODY    = 3'd4
    } frame_phase_t;

    typedef enum logic [2:0] {
        ROLE_SU_LEN  = 3'd0,
        ROLE_SU_BODY = 3'd1,
        ROLE_TYPE    = 3'd2,
        ROLE_LEN     = 3'd3,
        ROLE_BODY    = 3'd4,
        ROLE_DISCARD = 3'd5
    } byte_role_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       chunk_end;
        logic       new_connection;
    } pgdfr_req_t;

    typedef struct packed {
        logic [7:0]               byte_out;
        byte_role_t               byte_role;
        logic [7:0]               message_type;
        logic [31:0]              declared_length;
        logic [BODY_OFFSET_W-1:0] body_offset;
        logic                     message_end;
        logic                     length_error;
    } pgdfr_rsp_t;

endpackage

`default_nettype wire

// ----- sv/pgdfr_input_stage.sv -----
// input register for byte requests
// depends on pgdfr_pkg for the request type
`default_nettype none

module pgdfr_input_stage
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  pgdfr_pkg::pgdfr_req_t  in_data,
    output logic                   s1_valid,
    output pgdfr_pkg::pgdfr_req_t  s1_data,
    input  wire                    s1_take
);
    import pgdfr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    pgdfr_req_t data_reg;
    pgdfr_req_t data_next;
    logic       accept;

    assign in_stall = valid_reg && !s1_take;
    assign accept   = in_valid && !in_stall;
    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            data_next  = in_data;
        end
        else if (s1_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ----- sv/pgdfr_framer.sv -----
// framing state and per-byte tagging logic
// depends on pgdfr_pkg for phases, roles and request/result types
`default_nettype none

module pgdfr_framer
#(
    parameter int unsigned OFFSET_WIDTH = pgdfr_pkg::OFFSET_WIDTH_DEFAULT
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    cfg_write_en,
    input  wire  [31:0]            cfg_write_data,
    input  wire                    advance,
    input  pgdfr_pkg::pgdfr_req_t  req,
    output pgdfr_pkg::pgdfr_rsp_t  rsp
);
    import pgdfr_pkg::*;

    logic [31:0]             max_total_reg;

    logic                    startup_reg;
    logic                    startup_next;
    frame_phase_t            phase_reg;
    frame_phase_t            phase_next;
    logic [31:0]             hdr_reg;
    logic [31:0]             hdr_next;
    logic [2:0]              cnt_reg;
    logic [2:0]              cnt_next;
    logic [7:0]              type_reg;
    logic [7:0]              type_next;
    logic [31:0]             rem_reg;
    logic [31:0]             rem_next;
    logic [OFFSET_WIDTH-1:0] pos_reg;
    logic [OFFSET_WIDTH-1:0] pos_next;
    logic                    discard_reg;
    logic                    discard_next;

    logic                    c_startup;
    frame_phase_t            c_phase;
    logic [31:0]             c_hdr;
    logic [2:0]              c_cnt;
    logic [7:0]              c_type;
    logic [31:0]             c_rem;
    logic [OFFSET_WIDTH-1:0] c_pos;
    logic                    c_discard;

    logic [31:0]             hdr_shift;
    logic [2:0]              cnt_inc;
    logic [31:0]             rem_dec;

    // new connection clears framing before the byte is handled
    always_comb
    begin
        if (req.new_connection)
        begin
            c_startup = 1'b0;
            c_phase   = PH_SU_LEN;
            c_hdr     = '0;
            c_cnt     = '0;
            c_type    = '0;
            c_rem     = '0;
            c_pos     = '0;
            c_discard = 1'b0;
        end
        else
        begin
            c_startup = startup_reg;
            c_phase   = phase_reg;
            c_hdr     = hdr_reg;
            c_cnt     = cnt_reg;
            c_type    = type_reg;
            c_rem     = rem_reg;
            c_pos     = pos_reg;
            c_discard = discard_reg;
        end
    end

    assign hdr_shift = {c_hdr[23:0], req.data_byte};
    assign cnt_inc   = c_cnt + 3'd1;
    assign rem_dec   = (c_rem != 32'd0) ? (c_rem - 32'd1) : 32'd0;

    always_comb
    begin
        startup_next = c_startup;
        phase_next   = c_phase;
        hdr_next     = c_hdr;
        cnt_next     = c_cnt;
        type_next    = c_type;
        rem_next     = c_rem;
        pos_next     = c_pos;
        discard_next = c_discard;

        rsp.byte_out        = req.data_byte;
        rsp.byte_role       = ROLE_DISCARD;
        rsp.declared_length = '0;
        rsp.body_offset     = '0;
        rsp.message_end     = 1'b0;
        rsp.length_error    = 1'b0;

        if (c_discard)
        begin
            rsp.declared_length = c_hdr;
            if (req.chunk_end)
            begin
                discard_next = 1'b0;
                phase_next   = PH_TYPE;
            end
        end
        else
        begin
            case (c_phase)
                PH_SU_LEN:
                begin
                    rsp.byte_role = ROLE_SU_LEN;
                    hdr_next      = hdr_shift;
                    cnt_next      = cnt_inc;
                    if (cnt_inc >= HDR_COUNT_FULL)
                    begin
                        startup_next = 1'b1;
                        if (hdr_shift < HDR_LEN || hdr_shift > max_total_reg)
                        begin
                            // not a startup length: reuse as type plus three length bytes
                            type_next  = hdr_shift[31:24];
                            hdr_next   = {8'h00, hdr_shift[23:0]};
                            cnt_next   = HDR_COUNT_REUSE;
                            phase_next = PH_LEN;
                        end
                        else
                        begin
                            rsp.declared_length = hdr_shift;
                            if (hdr_shift == HDR_LEN)
                            begin
                                rsp.message_end = 1'b1;
                                phase_next      = PH_TYPE;
                            end
                            else
                            begin
                                rem_next   = hdr_shift - HDR_LEN;
                                pos_next   = '0;
                                phase_next = PH_SU_BODY;
                            end
                        end
                    end
                end
                PH_SU_BODY, PH_BODY:
                begin
                    rsp.byte_role       = (c_phase == PH_SU_BODY) ? ROLE_SU_BODY : ROLE_BODY;
                    rsp.declared_length = c_hdr;
                    rsp.body_offset     = BODY_OFFSET_W'(32'(c_pos));
                    pos_next            = c_pos + OFFSET_WIDTH'(1);
                    rem_next            = rem_dec;
                    if (rem_dec == 32'd0)
                    begin
                        rsp.message_end = 1'b1;
                        phase_next      = PH_TYPE;
                    end
                end
                PH_TYPE:
                begin
                    rsp.byte_role = ROLE_TYPE;
                    type_next     = req.data_byte;
                    hdr_next      = '0;
                    cnt_next      = '0;
                    phase_next    = PH_LEN;
                end
                default:
                begin
                    rsp.byte_role = ROLE_LEN;
                    hdr_next      = hdr_shift;
                    cnt_next      = cnt_inc;
                    if (cnt_inc >= HDR_COUNT_FULL)
                    begin
                        rsp.declared_length = hdr_shift;
                        // length + 1 > limit is the same as length >= limit
                        if (hdr_shift < HDR_LEN || hdr_shift >= max_total_reg)
                        begin
                            rsp.length_error = 1'b1;
                            phase_next       = PH_TYPE;
                            discard_next     = !req.chunk_end;
                        end
                        else if (hdr_shift == HDR_LEN)
                        begin
                            rsp.message_end = 1'b1;
                            phase_next      = PH_TYPE;
                        end
                        else
                        begin
                            rem_next   = hdr_shift - HDR_LEN;
                            pos_next   = '0;
                            phase_next = PH_BODY;
                        end
                    end
                end
            endcase
        end

        rsp.message_type = startup_next ? type_next : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_total_reg <= MAX_TOTAL_DEFAULT;
        end
        else if (cfg_write_en)
        begin
            max_total_reg <= cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            startup_reg <= 1'b0;
            phase_reg   <= PH_SU_LEN;
            hdr_reg     <= '0;
            cnt_reg     <= '0;
            type_reg    <= '0;
            rem_reg     <= '0;
            pos_reg     <= '0;
            discard_reg <= 1'b0;
        end
        else if (advance)
        begin
            startup_reg <= startup_next;
            phase_reg   <= phase_next;
            hdr_reg     <= hdr_next;
            cnt_reg     <= cnt_next;
            type_reg    <= type_next;
            rem_reg     <= rem_next;
            pos_reg     <= pos_next;
            discard_reg <= discard_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_discard_phase: assert property (@(posedge clk) disable iff (!rst_n)
        discard_reg |-> phase_reg == PH_TYPE)
        else $error("discard mode outside type phase");

    a_err_on_len: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rsp.length_error |-> rsp.byte_role == ROLE_LEN && !rsp.message_end)
        else $error("length error on a non-length byte");

    a_end_role: assert property (@(posedge clk) disable iff (!rst_n)
        advance && rsp.message_end |-> rsp.byte_role == ROLE_SU_LEN
            || rsp.byte_role == ROLE_SU_BODY || rsp.byte_role == ROLE_LEN
            || rsp.byte_role == ROLE_BODY)
        else $error("message end on a type or discarded byte");

    a_body_phase_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_SU_BODY || phase_reg == PH_BODY) && !discard_reg
            |-> rem_reg != 32'd0)
        else $error("body phase with nothing remaining");
`endif

endmodule

`default_nettype wire

// ----- sv/pgdfr_output_stage.sv -----
// result register toward the receiver
// depends on pgdfr_pkg for the result type
`default_nettype none

module pgdfr_output_stage
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    s1_valid,
    output logic                   s1_take,
    input  pgdfr_pkg::pgdfr_rsp_t  s1_rsp,
    output logic                   out_valid,
    input  wire                    out_stall,
    output pgdfr_pkg::pgdfr_rsp_t  out_data
);
    import pgdfr_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    pgdfr_rsp_t data_reg;
    pgdfr_rsp_t data_next;
    logic       load;

    assign s1_take   = !valid_reg || !out_stall;
    assign load      = s1_valid && s1_take;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load)
        begin
            valid_next = 1'b1;
            data_next  = s1_rsp;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

// ----- sv/pg_frontend_message_deframer_unit.sv -----
// frontend message deframer: one client byte in, one tagged byte out
// uses pgdfr_pkg, pgdfr_input_stage, pgdfr_framer and pgdfr_output_stage
//
// usage
//   in channel: in_valid/in_stall carry one request per byte (data_byte,
//   chunk_end, new_connection). out channel: out_valid/out_stall carry one
//   result per request: the byte with its role, message type, declared
//   length, body offset, end mark and length error flag.
//   cfg_write_en/cfg_write_data set the largest accepted message size; write
//   only while no request is in flight.
// timing
//   out_valid rises once an accepted request has gone from the input
//   register into the result register; one request per cycle is sustained
//   while out_stall is low, set by the single framing step between the two.
// reset
//   rst_n clears framing to expect a startup length and loads the default
//   64 MiB limit; new_connection clears framing the same way for its byte.
// stall
//   a stalled result holds in the result register while one more request is
//   taken into the input register; in_stall rises after that.
`default_nettype none

module pg_frontend_message_deframer_unit
#(
    parameter int unsigned OFFSET_WIDTH = pgdfr_pkg::OFFSET_WIDTH_DEFAULT
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    in_valid,
    output logic                   in_stall,
    input  pgdfr_pkg::pgdfr_req_t  in_data,
    output logic                   out_valid,
    input  wire                    out_stall,
    output pgdfr_pkg::pgdfr_rsp_t  out_data,
    input  wire                    cfg_write_en,
    input  wire  [31:0]            cfg_write_data
);
    import pgdfr_pkg::*;

    logic       s1_valid;
    logic       s1_take;
    pgdfr_req_t s1_data;
    pgdfr_rsp_t s1_rsp;
    logic       advance;

    assign advance = s1_valid && s1_take;

    pgdfr_input_stage u_input_stage
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s1_take  (s1_take)
    );

    pgdfr_framer #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_framer
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .advance        (advance),
        .req            (s1_data),
        .rsp            (s1_rsp)
    );

    pgdfr_output_stage u_output_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_take   (s1_take),
        .s1_rsp    (s1_rsp),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef NO_ASSERTIONS
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without a stalled result");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("request advanced but no result shown");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
